FILE: rtl/lms_adaptive_noise_canceller_core_assert.svh
// Assertion macros used by the checker of the LMS noise canceller core
`ifndef LMS_ADAPTIVE_NOISE_CANCELLER_CORE_ASSERT_SVH
`define LMS_ADAPTIVE_NOISE_CANCELLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define LANC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lanc checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is low
`define LANC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lanc checker: next-cycle property failed");

`endif

FILE: rtl/lanc_pkg.sv
// Shared constants, command and status types of the LMS noise canceller
`timescale 1ns / 1ps
`default_nettype none

package lanc_pkg;

    // Filter length and tap index width
    localparam int TAPS   = 50;
    localparam int TAP_AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [TAP_AW-1:0] TAP_LAST = TAP_AW'(TAPS - 1);

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 32;
    localparam int STEP_W   = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

    // Datapath widths: mu*err, shared multiplier product, accumulator
    localparam int MUE_W  = STEP_W + 1 + SAMPLE_W;
    localparam int PROD_W = MUE_W + SAMPLE_W;
    localparam int ACC_W  = SAMPLE_W + WEIGHT_W + TAP_AW;

    // Error rounding: Q.39 difference down to Q.15
    localparam int ERR_FRAC = 24;
    localparam int DIFF_W   = ACC_W + 2;
    localparam logic signed [DIFF_W-1:0] ERR_HALF = DIFF_W'(1) <<< (ERR_FRAC - 1);

    // Weight update rounding: Q.46 step down to Q.24 with doubling
    localparam int UPD_SHIFT = 21;
    localparam int UPD_W     = WEIGHT_W + UPD_SHIFT + 2;
    localparam logic signed [UPD_W-1:0] UPD_HALF = UPD_W'(1) <<< (UPD_SHIFT - 1);

    // Saturation limits
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    // Controller to datapath commands
    typedef struct packed {
        logic              load;      // take the item, write history
        logic              rd_mac;    // read tap for the estimate sweep
        logic              rd_upd;    // read tap for the weight update sweep
        logic [TAP_AW-1:0] tap;       // tap index of the current read
        logic              calc_err;  // register the saturated error
        logic              push_out;  // load output register, form mu*err
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;  // reads still in flight in the tap pipeline
        logic out_free;   // output register can take an item this cycle
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/lanc_ram.sv
// Generic simple dual-port RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module lanc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 50,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/lanc_ctrl.sv
// Sequencer: item intake, estimate sweep, error, weight update sweep
`timescale 1ns / 1ps
`default_nettype none

module lanc_ctrl import lanc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd       o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MAC   = 7'b0000010,
        S_MWAIT = 7'b0000100,
        S_ERR   = 7'b0001000,
        S_OUT   = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_UWAIT = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [TAP_AW-1:0] r_tap, n_tap;

    // Next state and command decode
    always_comb begin
        n_state  = r_state;
        n_tap    = r_tap;
        o_cmd    = '0;
        o_cmd.tap = r_tap;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_tap      = '0;
                    n_state    = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.rd_mac = 1'b1;
                if (r_tap == TAP_LAST) begin
                    n_tap   = '0;
                    n_state = S_MWAIT;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_MWAIT: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.push_out = 1'b1;
                    n_tap          = '0;
                    n_state        = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.rd_upd = 1'b1;
                if (r_tap == TAP_LAST) begin
                    n_tap   = '0;
                    n_state = S_UWAIT;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_UWAIT: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/lanc_dp.sv
// Datapath: history and weight RAMs, shared multiplier, accumulator, update
`timescale 1ns / 1ps
`default_nettype none

module lanc_dp import lanc_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_ctrl_cmd                  i_cmd,
    output t_dp_status                      o_status,
    input  wire logic signed [SAMPLE_W-1:0] i_primary_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_reference_sample,
    input  wire logic                       i_frame_start,
    input  wire logic                       i_cfg_we,
    input  wire logic        [STEP_W-1:0]   i_cfg_step_size,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed      [SAMPLE_W-1:0] o_error_sample
);

    // Item-level registers
    logic        [STEP_W-1:0]   r_step_size;
    logic        [TAP_AW-1:0]   r_head, n_head;
    logic signed [SAMPLE_W-1:0] r_primary;
    logic        [TAPS-1:0]     r_hvalid, n_hvalid;
    logic        [TAPS-1:0]     r_wvalid;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_err;
    logic signed [MUE_W-1:0]    r_mue;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    // Tap pipeline registers
    logic                       r_hv_q, r_wv_q;
    logic                       r_s1_mac, r_s1_upd;
    logic        [TAP_AW-1:0]   r_s1_addr;
    logic                       r_s2_mac, r_s2_upd;
    logic        [TAP_AW-1:0]   r_s2_addr;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [WEIGHT_W-1:0] r_s2_w;

    // Combinational nets
    logic        [TAP_AW-1:0]   hist_raddr;
    logic        [SAMPLE_W-1:0] hist_q;
    logic        [WEIGHT_W-1:0] w_q;
    logic signed [SAMPLE_W-1:0] hist_val;
    logic signed [WEIGHT_W-1:0] w_val;
    logic signed [MUE_W-1:0]    mul_a;
    logic signed [PROD_W-1:0]   mul_prod;
    logic signed [DIFF_W-1:0]   err_diff, err_q;
    logic        [SAMPLE_W-1:0] err_sat;
    logic signed [UPD_W-1:0]    upd_sum, upd_q;
    logic        [WEIGHT_W-1:0] w_new;
    logic                       w_we;

    // Newest sample goes one slot past the head; tap k sits k slots behind the head
    assign n_head = (r_head == TAP_LAST) ? '0 : r_head + 1'b1;
    assign hist_raddr = (r_head >= i_cmd.tap) ? r_head - i_cmd.tap
                                              : TAP_AW'(r_head + TAP_AW'(TAPS) - i_cmd.tap);

    // History valid bits: frame start drops all, new sample marks its slot
    always_comb begin
        n_hvalid = r_hvalid;
        if (i_cmd.load) begin
            if (i_frame_start) begin
                n_hvalid = '0;
            end
            n_hvalid = n_hvalid | ({{(TAPS-1){1'b0}}, 1'b1} << n_head);
        end
    end

    lanc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (n_head),
        .i_wdata (i_reference_sample),
        .i_raddr (hist_raddr),
        .o_rdata (hist_q)
    );

    lanc_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (TAPS)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s2_addr),
        .i_wdata (w_new),
        .i_raddr (i_cmd.tap),
        .o_rdata (w_q)
    );

    // Config, item intake and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= STEP_RESET;
            r_head      <= '0;
            r_hvalid    <= '0;
            r_wvalid    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_step_size <= i_cfg_step_size;
            end
            r_hvalid <= n_hvalid;
            if (i_cmd.load) begin
                r_head <= n_head;
            end
            if (i_cmd.load && i_frame_start) begin
                r_wvalid <= '0;
            end else if (w_we) begin
                r_wvalid[r_s2_addr] <= 1'b1;
            end
        end
    end

    // Stage 1: RAM data plus valid bits of the addressed slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_mac <= 1'b0;
            r_s1_upd <= 1'b0;
        end else begin
            r_s1_mac <= i_cmd.rd_mac;
            r_s1_upd <= i_cmd.rd_upd;
        end
        r_hv_q    <= r_hvalid[hist_raddr];
        r_wv_q    <= r_wvalid[i_cmd.tap];
        r_s1_addr <= i_cmd.tap;
    end

    // Unwritten slots read as zero
    assign hist_val = r_hv_q ? $signed(hist_q) : '0;
    assign w_val    = r_wv_q ? $signed(w_q) : '0;

    // Shared multiplier: weight*hist for the estimate, (mu*err)*hist for the update
    assign mul_a    = r_s1_mac ? MUE_W'(w_val) : r_mue;
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(hist_val);

    // Stage 2: product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_mac <= 1'b0;
            r_s2_upd <= 1'b0;
        end else begin
            r_s2_mac <= r_s1_mac;
            r_s2_upd <= r_s1_upd;
        end
        r_prod    <= mul_prod;
        r_s2_w    <= w_val;
        r_s2_addr <= r_s1_addr;
    end

    // Stage 3a: estimate accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc     <= '0;
            r_primary <= i_primary_sample;
        end else if (r_s2_mac) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Stage 3b: new weight = old + round(prod / 2^21), saturated to 32 bits
    assign upd_sum = (UPD_W'(r_s2_w) <<< UPD_SHIFT) + UPD_W'(r_prod) + UPD_HALF;
    assign upd_q   = upd_sum >>> UPD_SHIFT;
    always_comb begin
        if (&upd_q[UPD_W-1:WEIGHT_W-1] || ~|upd_q[UPD_W-1:WEIGHT_W-1]) begin
            w_new = upd_q[WEIGHT_W-1:0];
        end else begin
            w_new = upd_q[UPD_W-1] ? WEIGHT_MIN : WEIGHT_MAX;
        end
    end
    assign w_we = r_s2_upd;

    // Error: primary aligned to Q.39 minus estimate, rounded and saturated to Q1.15
    assign err_diff = (DIFF_W'(r_primary) <<< ERR_FRAC) - DIFF_W'(r_acc) + ERR_HALF;
    assign err_q    = err_diff >>> ERR_FRAC;
    always_comb begin
        if (&err_q[DIFF_W-1:SAMPLE_W-1] || ~|err_q[DIFF_W-1:SAMPLE_W-1]) begin
            err_sat = err_q[SAMPLE_W-1:0];
        end else begin
            err_sat = err_q[DIFF_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end
    end

    // Error register and mu*err for the update sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_err) begin
            r_err <= $signed(err_sat);
        end
        if (i_cmd.push_out) begin
            r_mue <= MUE_W'($signed({1'b0, r_step_size})) * MUE_W'(r_err);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.push_out) begin
            r_out_data <= r_err;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_error_sample     = r_out_data;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_status.pipe_busy = r_s1_mac || r_s1_upd || r_s2_mac || r_s2_upd;

endmodule

`default_nettype wire

FILE: rtl/lms_adaptive_noise_canceller_core.sv
// LMS adaptive FIR noise canceller: top level
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: primary sample,
//   reference sample and frame-start flag. An item is taken on an edge with
//   i_in_valid high and o_in_stall low. Output channel (o_out_valid /
//   i_out_stall) carries one error sample per item.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the step size mu; ready
//   is always high. Write it only while no item is in progress.
//   Timing: the result reaches the output register after the estimate sweep
//   and the error step; the block takes no new item until the weight update
//   sweep ends. Both sweeps pass every tap through one shared multiplier
//   with single-port reads of the history and weight RAMs.
//   A stalled receiver holds the result in the output register; the block
//   keeps working and waits only if a second result is due before the first
//   is taken.
//   Reset (synchronous, active low) zeroes weights and history through
//   per-slot valid bits, restores mu to 655 and empties the output register.
//   A frame start clears weights and history in the same way, no sweep.
`timescale 1ns / 1ps
`default_nettype none

module lms_adaptive_noise_canceller_core import lanc_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_primary_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_reference_sample,
    input  wire logic                       i_frame_start,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed      [SAMPLE_W-1:0] o_error_sample,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic        [STEP_W-1:0]   i_cfg_step_size
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Config register always takes a write
    assign o_cfg_ready = 1'b1;

    lanc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lanc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_primary_sample   (i_primary_sample),
        .i_reference_sample (i_reference_sample),
        .i_frame_start      (i_frame_start),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_step_size    (i_cfg_step_size),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_error_sample     (o_error_sample)
    );

endmodule

`default_nettype wire

FILE: rtl/lanc_checker.sv
// Port-level checker of the LMS noise canceller, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "lms_adaptive_noise_canceller_core_assert.svh"

module lanc_checker import lanc_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire logic [SAMPLE_W-1:0] o_error_sample
);

    // One item at a time: intake closes right after an item is taken
    `LANC_ASSERT_SAME(a_stall_after_accept, i_clk, i_rst_n, $past(i_in_valid && !o_in_stall), o_in_stall)

    // A result never appears the cycle after an item is taken
    `LANC_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, i_in_valid && !o_in_stall, !$rose(o_out_valid))

    // Stalled result stays offered and unchanged
    `LANC_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `LANC_ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_error_sample))

endmodule

bind lms_adaptive_noise_canceller_core lanc_checker u_lanc_checker (.*);

`default_nettype wire

FILE: sim/lms_canceller_checker.sv
// Checker for the LMS noise canceller: tracks filter state and compares each error item
`timescale 1ns / 1ps

module lms_canceller_checker import lanc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_primary_sample,
    input  logic signed [SAMPLE_W-1:0] i_reference_sample,
    input  logic                       i_frame_start,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [SAMPLE_W-1:0] i_error_sample,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic        [STEP_W-1:0]   i_cfg_step_size,
    output int                         o_mismatches,
    output int                         o_pending
);

    // Saturation bounds and rounding offsets, widened to 64 bits
    localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_LO = -(longint'(1) <<< (SAMPLE_W - 1));
    localparam longint WEIGHT_HI = (longint'(1) <<< (WEIGHT_W - 1)) - 1;
    localparam longint WEIGHT_LO = -(longint'(1) <<< (WEIGHT_W - 1));
    localparam longint ERR_ROUND = longint'(1) <<< (ERR_FRAC - 1);
    localparam longint UPD_ROUND = longint'(1) <<< (UPD_SHIFT - 1);

    typedef struct {
        int                         seq;
        logic signed [SAMPLE_W-1:0] error_sample;
    } t_error_item;

    // Filter state mirrored from the accepted items
    logic signed [SAMPLE_W-1:0] ref_line [TAPS];
    logic signed [WEIGHT_W-1:0] tap_gain [TAPS];
    logic        [STEP_W-1:0]   mu;

    t_error_item expected_errors [$];
    int          items_taken = 0;
    int          fails = 0;

    // One LMS step: clear on a frame start, shift in the reference, estimate, error, adapt the weights
    function automatic logic signed [SAMPLE_W-1:0] cancel_noise(
        input logic signed [SAMPLE_W-1:0] primary,
        input logic signed [SAMPLE_W-1:0] reference,
        input logic                       frame_start
    );
        longint                     estimate;
        longint                     diff;
        longint                     err_wide;
        longint                     mu_wide;
        longint                     adjust;
        longint                     gain_next;
        logic signed [SAMPLE_W-1:0] err;
        int                         k;

        if (frame_start) begin
            for (k = 0; k < TAPS; k++) begin
                ref_line[k] = '0;
                tap_gain[k] = '0;
            end
        end
        for (k = TAPS - 1; k > 0; k--) begin
            ref_line[k] = ref_line[k - 1];
        end
        ref_line[0] = reference;

        // estimate uses the weights from before this item
        estimate = 0;
        for (k = 0; k < TAPS; k++) begin
            estimate += longint'(tap_gain[k]) * longint'(ref_line[k]);
        end
        diff     = (longint'(primary) <<< ERR_FRAC) - estimate;
        err_wide = (diff + ERR_ROUND) >>> ERR_FRAC;
        if (err_wide > SAMPLE_HI) err_wide = SAMPLE_HI;
        if (err_wide < SAMPLE_LO) err_wide = SAMPLE_LO;
        err = err_wide[SAMPLE_W-1:0];

        // update from the clamped error, weights saturate
        mu_wide = mu;
        for (k = 0; k < TAPS; k++) begin
            adjust    = (mu_wide * longint'(err) * longint'(ref_line[k]) + UPD_ROUND)
                        >>> UPD_SHIFT;
            gain_next = longint'(tap_gain[k]) + adjust;
            if (gain_next > WEIGHT_HI) gain_next = WEIGHT_HI;
            if (gain_next < WEIGHT_LO) gain_next = WEIGHT_LO;
            tap_gain[k] = gain_next[WEIGHT_W-1:0];
        end
        return err;
    endfunction

    // Watch the three channels at each edge
    always @(posedge i_clk) begin : watch
        t_error_item fresh;
        t_error_item oldest;
        int          k;

        if (!i_rst_n) begin
            mu = STEP_RESET;
            for (k = 0; k < TAPS; k++) begin
                ref_line[k] = '0;
                tap_gain[k] = '0;
            end
            expected_errors.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                mu = i_cfg_step_size;
            end
            if (i_in_valid && !i_in_stall) begin
                fresh.seq          = items_taken;
                fresh.error_sample = cancel_noise(i_primary_sample, i_reference_sample,
                                                  i_frame_start);
                expected_errors.push_back(fresh);
                items_taken++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_errors.size() == 0) begin
                    $display("%0t: error item %0d arrived with none expected",
                             $time, i_error_sample);
                    fails++;
                end else begin
                    oldest = expected_errors.pop_front();
                    if (oldest.error_sample !== i_error_sample) begin
                        $display("%0t: item %0d error_sample expected %0d actual %0d",
                                 $time, oldest.seq, oldest.error_sample, i_error_sample);
                        fails++;
                    end
                end
            end
        end
        o_mismatches <= fails;
        o_pending    <= expected_errors.size();
    end

endmodule

FILE: sim/lms_adaptive_noise_canceller_core_test.sv
// Top of the LMS noise canceller test: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module lms_adaptive_noise_canceller_core_test;
    import lanc_pkg::*;

    // Cycles for the weight update sweep to finish after the last error item
    localparam int SETTLE     = 2 * TAPS + 20;
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASES     = 7;
    localparam int PHASE_ITEMS = 220;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] i_primary_sample = '0;
    logic signed [SAMPLE_W-1:0] i_reference_sample = '0;
    logic                       i_frame_start = 1'b0;
    logic                       i_out_stall = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic        [STEP_W-1:0]   i_cfg_step_size = '0;

    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_error_sample;
    logic                       o_cfg_ready;

    int mismatches;
    int errors_pending;
    int idle_cycles = 0;
    bit quiet = 1'b0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    lms_adaptive_noise_canceller_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_primary_sample   (i_primary_sample),
        .i_reference_sample (i_reference_sample),
        .i_frame_start      (i_frame_start),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_error_sample     (o_error_sample),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_step_size    (i_cfg_step_size)
    );

    lms_canceller_checker checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_primary_sample   (i_primary_sample),
        .i_reference_sample (i_reference_sample),
        .i_frame_start      (i_frame_start),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_error_sample     (o_error_sample),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_step_size    (i_cfg_step_size),
        .o_mismatches       (mismatches),
        .o_pending          (errors_pending)
    );

    // Offer one item after a random gap, none in quiet runs, and hold it until taken
    task automatic offer_item(
        input logic signed [SAMPLE_W-1:0] primary,
        input logic signed [SAMPLE_W-1:0] reference,
        input logic                       frame_start
    );
        int gap;

        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_primary_sample   <= primary;
        i_reference_sample <= reference;
        i_frame_start      <= frame_start;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop offering, wait for every error item, then let the update sweep end
    task automatic drain_block();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (errors_pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] step);
        i_cfg_valid     <= 1'b1;
        i_cfg_step_size <= step;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Frames opened by a frame start; half of them, on average, carry a primary built from the
    // delayed reference so that the filter has something to converge on
    task automatic feed_frames(input int count);
        int   left;
        int   len;
        int   kind;
        int   lag;
        int   k;
        int   j;
        int   p;
        int   r;
        int   past [8];
        logic f;

        left = count;
        while (left > 0) begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8)
                                               : $urandom_range(20, 160);
            if (len > left) len = left;
            kind = $urandom_range(0, 9);
            lag  = $urandom_range(0, 6);
            for (k = 0; k < 8; k++) past[k] = 0;
            for (k = 0; k < len; k++) begin
                r = int'($urandom_range(0, 65535)) - 32768;
                if (kind <= 4) begin
                    for (j = 7; j > 0; j--) past[j] = past[j - 1];
                    past[0] = r;
                    p = (past[lag] >>> 1) + (past[lag + 1] >>> 2)
                        + int'($urandom_range(0, 63)) - 32;
                end else if (kind == 7) begin
                    r = $urandom_range(0, 1) ? 32767 : -32768;
                    p = $urandom_range(0, 1) ? 32767 : -32768;
                end else if (kind == 8) begin
                    r = int'($urandom_range(0, 63)) - 32;
                    p = int'($urandom_range(0, 63)) - 32;
                end else begin
                    p = int'($urandom_range(0, 65535)) - 32768;
                end
                // one kind of noisy frame also gets frame starts at random places
                f = (k == 0) || (kind == 9 && $urandom_range(0, 3) == 0);
                offer_item(p[SAMPLE_W-1:0], r[SAMPLE_W-1:0], f);
            end
            left -= len;
        end
    endtask

    // Receiver: random stall per item, two long hold-offs, some quiet runs
    initial begin : error_sink
        int hold;
        int taken;

        taken = 0;
        forever begin
            if (taken == 300 || taken == 1100) begin
                hold = 400;
            end else if ((taken / 128) % 4 == 2) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 4);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        logic [STEP_W-1:0] step_plan [PHASES];
        int                ph;

        step_plan = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'd655, 16'd0, 16'h0100};
        step_plan[5] = STEP_W'($urandom_range(0, 65535));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset step size
        offer_item(16'sd0, 16'sd0, 1'b1);
        offer_item(16'sh7FFF, 16'sh7FFF, 1'b0);
        offer_item(16'sh8000, 16'sh8000, 1'b0);
        offer_item(16'sh7FFF, 16'sh8000, 1'b0);
        offer_item(16'sh8000, 16'sh7FFF, 1'b0);
        offer_item(16'sd1, -16'sd1, 1'b0);
        offer_item(-16'sd1, 16'sd1, 1'b0);
        offer_item(16'sh5555, 16'shAAAA, 1'b0);
        offer_item(16'shAAAA, 16'sh5555, 1'b0);
        // frame start after adaptation must clear weights and history
        offer_item(16'sh1234, -16'sd7, 1'b1);
        // steady full-scale drive grows the weights
        repeat (12) offer_item(16'sh7FFF, 16'sh8000, 1'b0);
        offer_item(16'sh8000, 16'sh8000, 1'b0);
        offer_item(16'sh8000, 16'sh7FFF, 1'b0);
        drain_block();

        // Random frames, one step size per phase
        for (ph = 0; ph < PHASES; ph++) begin
            write_step(step_plan[ph]);
            quiet = (ph % 3 == 2);
            feed_frames(PHASE_ITEMS);
            drain_block();
        end

        if (mismatches == 0 && errors_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
